>>> hw/rtl/bpc_pkg.sv
// Package for the barometric pressure compensation core.
// Holds widths, register indexes, compensation constants and small helpers.
// No dependencies; every other file imports it.
`default_nettype none

package bpc_pkg;

  localparam int CfgW       = 48;
  localparam int CfgIdxW    = 3;
  localparam int DivW       = 32;
  localparam int SideW      = 64;
  localparam int RawTempW   = 16;
  localparam int RawPressW  = 19;
  localparam int PressW     = 32;
  localparam int TempW      = 16;

  localparam logic [CfgIdxW-1:0] RegCoefA    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefB    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefQuad = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefTemp = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOsMode   = 3'd4;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] KBase      = 32'd50000;
  localparam logic [31:0] KHalf      = 32'd32768;
  localparam logic [31:0] KQuad      = 32'd3038;
  localparam logic [31:0] KLin       = 32'd7357;
  localparam logic [31:0] KOff       = 32'd3791;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bpc_if.sv
// Stream interfaces for the compensation core: raw sample in, result out.
// Depends on bpc_pkg for field widths.
`default_nettype none

interface bpc_sample_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [RawTempW-1:0]  raw_temp_word;
  logic [RawPressW-1:0] raw_press_word;
  modport source (output valid, raw_temp_word, raw_press_word, input ready);
  modport sink   (input valid, raw_temp_word, raw_press_word, output ready);
endinterface

interface bpc_result_if;
  import bpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PressW-1:0] pressure_pa;
  logic signed [TempW-1:0]  temp_tenths;
  logic                     div_fault;
  modport source (output valid, pressure_pa, temp_tenths, div_fault, input ready);
  modport sink   (input valid, pressure_pa, temp_tenths, div_fault, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/barometer_pressure_compensation_core.sv
// Barometric pressure compensation core, 32-bit integer scheme.
// Depends on bpc_pkg, bpc_if (sample/result interfaces) and bpc_div.
//
// Usage:
//   - Write calibration through cfg_we/cfg_index/cfg_wdata while the core is
//     idle: index 0 ac1/ac2/ac3, 1 ac4/ac5/ac6, 2 b1/b2, 3 mc/md, 4 mode.
//     Indexes past 4 are ignored.
//   - Each item accepted on 'sample' (raw temperature and raw pressure)
//     yields exactly one item on 'result': pressure in pascals, temperature
//     in tenths of a degree (saturated to 16 bits) and a divide fault flag.
//     On a zero divisor the fault is set and both values read zero.
//   - The pipeline has 78 register stages, from the sample capture register
//     to the result register. The two 32-stage dividers (temperature term
//     and pressure term) set most of that; the rest is 14 capture,
//     multiply/add and output stages around them. Every stage carries a
//     valid bit. Throughput is one item per cycle unless the receiver stalls.
//   - When the receiver stalls with a result pending, the whole pipeline
//     holds; sample.ready drops in the same cycle and nothing is lost.
//   - Reset (rst, synchronous) clears all valid bits and the registers:
//     coefficients to zero, oversampling mode to 3.
`default_nettype none

module barometer_pressure_compensation_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bpc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bpc_pkg::CfgW-1:0]    cfg_wdata,
  bpc_sample_if.sink                       sample,
  bpc_result_if.source                     result
);
  import bpc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [47:0] coef_a;
  logic [47:0] coef_b;
  logic [31:0] coef_quad;
  logic [31:0] coef_temp;
  logic [1:0]  os_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a    <= '0;
      coef_b    <= '0;
      coef_quad <= '0;
      coef_temp <= '0;
      os_mode   <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCoefA:    coef_a    <= cfg_wdata;
        RegCoefB:    coef_b    <= cfg_wdata;
        RegCoefQuad: coef_quad <= cfg_wdata[31:0];
        RegCoefTemp: coef_temp <= cfg_wdata[31:0];
        RegOsMode:   os_mode   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sext16(coef_a[47:32]);
  assign ac2 = sext16(coef_a[31:16]);
  assign ac3 = sext16(coef_a[15:0]);
  assign ac4 = {16'd0, coef_b[47:32]};
  assign ac5 = {16'd0, coef_b[31:16]};
  assign ac6 = {16'd0, coef_b[15:0]};
  assign b1  = sext16(coef_quad[31:16]);
  assign b2  = sext16(coef_quad[15:0]);
  assign mc  = sext16(coef_temp[31:16]);
  assign md  = sext16(coef_temp[15:0]);

  // ---------------- pipeline control ----------------
  // Advance everything unless a result is waiting and the receiver holds off.
  logic en;
  logic res_v;
  assign en           = !res_v || result.ready;
  assign sample.ready = en;

  // ---------------- s0: capture item ----------------
  logic        v0;
  logic [15:0] ut0;
  logic [18:0] up0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= sample.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ut0 <= sample.raw_temp_word;
      up0 <= sample.raw_press_word;
    end
  end

  // ---------------- s1: (UT - ac6) * ac5 ----------------
  logic        v1;
  logic [31:0] prod1;
  logic [18:0] up1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ({16'd0, ut0} - ac6) * ac5;
      up1   <= up0;
    end
  end

  // ---------------- s2: X1 and temperature divisor ----------------
  logic        v2;
  logic [31:0] x1_2, divt2;
  logic        fault2;
  logic [18:0] up2;
  logic [31:0] x1_n;
  assign x1_n = 32'($signed(prod1) >>> 15);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1_2   <= x1_n;
      divt2  <= x1_n + md;
      fault2 <= (x1_n + md) == 32'd0;
      up2    <= up1;
    end
  end

  // ---------------- divider A: (mc << 11) / (X1 + md), signed ----------------
  logic [31:0] numa, numa_mag, dena_mag;
  logic        signa;
  logic [SideW-1:0] sidea_in, sidea_out;
  logic        va;
  logic [31:0] qa;
  assign numa     = mc << 11;
  assign numa_mag = numa[31] ? (32'd0 - numa) : numa;
  assign dena_mag = fault2 ? 32'd1 : (divt2[31] ? (32'd0 - divt2) : divt2);
  assign signa    = numa[31] ^ divt2[31];
  assign sidea_in = {x1_2, up2, fault2, signa, 11'd0};

  bpc_div u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .num      (numa_mag),
    .den      (dena_mag),
    .side_in  (sidea_in),
    .out_valid(va),
    .quot     (qa),
    .side_out (sidea_out)
  );

  // ---------------- s4: B5 ----------------
  logic        v4, fault4;
  logic [31:0] b5_4;
  logic [18:0] up4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b5_4   <= sidea_out[63:32] + (sidea_out[11] ? (32'd0 - qa) : qa);
      up4    <= sidea_out[31:13];
      fault4 <= sidea_out[12];
    end
  end

  // ---------------- s5: B6 ----------------
  logic        v5, fault5;
  logic [31:0] b5_5, b6_5;
  logic [18:0] up5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b5_5   <= b5_4;
      b6_5   <= b5_4 - TempOffset;
      up5    <= up4;
      fault5 <= fault4;
    end
  end

  // ---------------- s6: B6 products ----------------
  logic        v6, fault6;
  logic [31:0] b5_6, ss6, m2_6, m3_6;
  logic [18:0] up6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ss6    <= b6_5 * b6_5;
      m2_6   <= ac2 * b6_5;
      m3_6   <= ac3 * b6_5;
      b5_6   <= b5_5;
      up6    <= up5;
      fault6 <= fault5;
    end
  end

  // ---------------- s7: coefficient products of the square ----------------
  logic        v7, fault7;
  logic [31:0] b5_7, p1_7, p2_7, x2a_7, x1c_7;
  logic [18:0] up7;
  logic [31:0] sq6;
  assign sq6 = 32'($signed(ss6) >>> 12);
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1_7   <= b2 * sq6;
      p2_7   <= b1 * sq6;
      x2a_7  <= 32'($signed(m2_6) >>> 11);
      x1c_7  <= 32'($signed(m3_6) >>> 13);
      b5_7   <= b5_6;
      up7    <= up6;
      fault7 <= fault6;
    end
  end

  // ---------------- s8: X3 terms ----------------
  logic        v8, fault8;
  logic [31:0] b5_8, x3_8, x3b_8;
  logic [18:0] up8;
  logic [31:0] sum7;
  assign sum7 = x1c_7 + 32'($signed(p2_7) >>> 16) + 32'd2;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x3_8   <= 32'($signed(p1_7) >>> 11) + x2a_7;
      x3b_8  <= 32'($signed(sum7) >>> 2);
      b5_8   <= b5_7;
      up8    <= up7;
      fault8 <= fault7;
    end
  end

  // ---------------- s9: B3 and the B4 product ----------------
  logic        v9, fault9;
  logic [31:0] b5_9, b3_9, pb4_9;
  logic [18:0] up9;
  logic [31:0] b3raw;
  assign b3raw = (((ac1 << 2) + x3_8) << os_mode) + 32'd2;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // truncate toward zero: bias negatives before the shift
      b3_9   <= 32'($signed(b3raw[31] ? (b3raw + 32'd3) : b3raw) >>> 2);
      pb4_9  <= ac4 * (x3b_8 + KHalf);
      b5_9   <= b5_8;
      up9    <= up8;
      fault9 <= fault8;
    end
  end

  // ---------------- s10: B4 and B7 ----------------
  logic        v10, fault10;
  logic [31:0] b5_10, b4_10, b7_10;
  logic [31:0] kmode;
  assign kmode = KBase >> os_mode;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4_10   <= pb4_9 >> 15;
      b7_10   <= ({13'd0, up9} - b3_9) * kmode;
      b5_10   <= b5_9;
      fault10 <= fault9 || ((pb4_9 >> 15) == 32'd0);
    end
  end

  // ---------------- divider B: B7 / B4, unsigned ----------------
  logic [31:0] numb, denb;
  logic [SideW-1:0] sideb_in, sideb_out;
  logic        vb;
  logic [31:0] qb;
  assign numb     = b7_10[31] ? b7_10 : (b7_10 << 1);
  assign denb     = (b4_10 == 32'd0) ? 32'd1 : b4_10;
  assign sideb_in = {b5_10, b7_10[31], fault10, 30'd0};

  bpc_div u_div_press (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v10),
    .num      (numb),
    .den      (denb),
    .side_in  (sideb_in),
    .out_valid(vb),
    .quot     (qb),
    .side_out (sideb_out)
  );

  // ---------------- s12: p ----------------
  logic        v12, fault12;
  logic [31:0] b5_12, p12;
  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p12     <= sideb_out[31] ? (qb << 1) : qb;
      b5_12   <= sideb_out[63:32];
      fault12 <= sideb_out[30];
    end
  end

  // ---------------- s13: p products ----------------
  logic        v13, fault13;
  logic [31:0] b5_13, p13, x1a_13, t7_13;
  logic [31:0] ps12;
  assign ps12 = 32'($signed(p12) >>> 8);
  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (en) v13 <= v12;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1a_13  <= ps12 * ps12;
      t7_13   <= 32'd0 - (KLin * p12);
      p13     <= p12;
      b5_13   <= b5_12;
      fault13 <= fault12;
    end
  end

  // ---------------- s14: correction terms ----------------
  logic        v14, fault14;
  logic [31:0] b5_14, p14, m14, x2_14;
  always_ff @(posedge clk) begin
    if (rst) v14 <= 1'b0;
    else if (en) v14 <= v13;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m14     <= x1a_13 * KQuad;
      x2_14   <= 32'($signed(t7_13) >>> 16);
      p14     <= p13;
      b5_14   <= b5_13;
      fault14 <= fault13;
    end
  end

  // ---------------- s15: output register ----------------
  logic [31:0] corr, res_n, tw;
  logic [15:0] temp_n;
  assign corr  = 32'($signed(m14) >>> 16) + x2_14 + KOff;
  assign res_n = p14 + 32'($signed(corr) >>> 4);
  assign tw    = 32'($signed(b5_14 + 32'd8) >>> 4);

  always_comb begin
    if ($signed(tw) > 32'sd32767) begin
      temp_n = 16'h7fff;
    end else if ($signed(tw) < -32'sd32768) begin
      temp_n = 16'h8000;
    end else begin
      temp_n = tw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_v <= 1'b0;
    else if (en) res_v <= v14;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // drop the values on a zero divisor
      result.pressure_pa <= fault14 ? '0 : res_n;
      result.temp_tenths <= fault14 ? '0 : temp_n;
      result.div_fault   <= fault14;
    end
  end
  assign result.valid = res_v;

  // ---------------- assertions ----------------
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.div_fault |-> result.pressure_pa == 0 && result.temp_tenths == 0)
    else $error("fault item carries nonzero values");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    sample.ready == (!result.valid || result.ready))
    else $error("input ready disagrees with output backpressure");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(v14) && $stable(p14) && $stable(v2))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

>>> hw/rtl/bpc_div.sv
// Pipelined unsigned 32-by-32 restoring divider, one quotient bit per stage.
// Carries a sideband word alongside each item; depends on bpc_pkg.
`default_nettype none

module bpc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [bpc_pkg::DivW-1:0]  num,
  input  wire logic [bpc_pkg::DivW-1:0]  den,
  input  wire logic [bpc_pkg::SideW-1:0] side_in,
  output logic                           out_valid,
  output logic [bpc_pkg::DivW-1:0]       quot,
  output logic [bpc_pkg::SideW-1:0]      side_out
);
  import bpc_pkg::*;

  logic            vld [DivW+1];
  logic [DivW-1:0] rem [DivW+1];
  logic [DivW-1:0] qs  [DivW+1];
  logic [DivW-1:0] dv  [DivW+1];
  logic [SideW-1:0] sd [DivW+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign qs[0]  = num;
  assign dv[0]  = den;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < DivW; i++) begin : g_step
    logic [DivW:0] trial;
    logic [DivW:0] diff;
    assign trial = {rem[i], qs[i][DivW-1]};
    assign diff  = trial - {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= diff[DivW] ? trial[DivW-1:0] : diff[DivW-1:0];
        qs[i+1]  <= {qs[i][DivW-2:0], ~diff[DivW]};
        dv[i+1]  <= dv[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[DivW];
  assign quot      = qs[DivW];
  assign side_out  = sd[DivW];

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench for barometer_pressure_compensation_core: random and directed raw
// samples against an in-bench integer compensation predictor.
// Depends on bpc_pkg and bpc_if from the RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  typedef struct packed {
    logic [RawTempW-1:0]  ut;
    logic [RawPressW-1:0] up;
  } raw_sample_t;

  typedef struct packed {
    logic signed [PressW-1:0] press;
    logic signed [TempW-1:0]  temp;
    logic                     fault;
  } comp_result_t;

  localparam int LatencyCycles = 78;
  localparam int CycleLimit    = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  bpc_sample_if sample();
  bpc_result_if result();

  barometer_pressure_compensation_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .sample(sample.sink), .result(result.source)
  );

  // Predictor copy of the calibration registers.
  logic [47:0] cal_a, cal_b;
  logic [31:0] cal_quad, cal_temp;
  logic [1:0]  os_mode;

  raw_sample_t  pending_samples[$];
  comp_result_t expected_results[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  faults_seen = 0;
  int  cycle_count = 0;
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;
  bit  send_hold = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Arithmetic shift of a 32-bit pattern; floor division by 2^s.
  function automatic logic [31:0] sar(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  // Signed divide, truncating toward zero, in 64 bits to avoid overflow traps.
  function automatic logic [31:0] sdiv32(input logic [31:0] n, input logic [31:0] d);
    longint q;
    q = longint'($signed(n)) / longint'($signed(d));
    return q[31:0];
  endfunction

  function automatic comp_result_t compensate(input raw_sample_t s);
    comp_result_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, div_t, b5, b6, sq, b3, b4, b7, p, res, t;
    int ti;
    ac1 = sext16(cal_a[47:32]); ac2 = sext16(cal_a[31:16]); ac3 = sext16(cal_a[15:0]);
    ac4 = {16'd0, cal_b[47:32]}; ac5 = {16'd0, cal_b[31:16]}; ac6 = {16'd0, cal_b[15:0]};
    b1 = sext16(cal_quad[31:16]); b2 = sext16(cal_quad[15:0]);
    mc = sext16(cal_temp[31:16]); md = sext16(cal_temp[15:0]);
    r = '{press: '0, temp: '0, fault: 1'b1};
    // temperature term
    x1 = sar(({16'd0, s.ut} - ac6) * ac5, 15);
    div_t = x1 + md;
    if (div_t == 0) return r;
    x2 = sdiv32(mc << 11, div_t);
    b5 = x1 + x2;
    // pressure term
    b6 = b5 - TempOffset;
    sq = sar(b6 * b6, 12);
    x3 = sar(b2 * sq, 11) + sar(ac2 * b6, 11);
    b3 = sdiv32(((ac1 * 32'd4 + x3) << os_mode) + 32'd2, 32'd4);
    x1 = sar(ac3 * b6, 13);
    x2 = sar(b1 * sq, 16);
    x3 = sar(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + KHalf)) >> 15;
    if (b4 == 0) return r;
    b7 = ({13'd0, s.up} - b3) * (KBase >> os_mode);
    p = (b7 < 32'h8000_0000) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
    x1 = sar(p, 8) * sar(p, 8);
    x1 = sar(x1 * KQuad, 16);
    x2 = sar(32'd0 - KLin * p, 16);
    res = p + sar(x1 + x2 + KOff, 4);
    t = sar(b5 + 32'd8, 4);
    ti = $signed(t);
    if (ti > 32767) ti = 32767;
    if (ti < -32768) ti = -32768;
    r.press = res;
    r.temp = 16'(ti);
    r.fault = 1'b0;
    return r;
  endfunction

  // Driver: present the head of the pending queue, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        expected_results.push_back(compensate(pending_samples.pop_front()));
      end
      // Decide once per edge whether an item stands for the next edge.
      if ((!sample.valid || sample.ready) ) begin
        if (pending_samples.size() != 0 &&
            !send_hold && !(send_idle_on && $urandom_range(99) < 33)) begin
          sample.valid <= 1'b1;
          sample.raw_temp_word  <= pending_samples[0].ut;
          sample.raw_press_word <= pending_samples[0].up;
        end else begin
          sample.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: accept results, stall at random, compare with the oldest guess.
  always @(posedge clk) begin
    comp_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result p=%0d t=%0d f=%0b", $time,
                   result.pressure_pa, result.temp_tenths, result.div_fault);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.fault) faults_seen <= faults_seen + 1;
          if (want.press !== result.pressure_pa || want.temp !== result.temp_tenths ||
              want.fault !== result.div_fault) begin
            $display("%0t: mismatch expected p=%0d t=%0d f=%0b actual p=%0d t=%0d f=%0b",
                     $time, want.press, want.temp, want.fault, result.pressure_pa,
                     result.temp_tenths, result.div_fault);
            mismatches <= mismatches + 1;
          end
        end
      end
      result.ready <= !(recv_idle_on && $urandom_range(99) < 33);
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Write one register; caller ensures the core is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegCoefA:    cal_a = val;
      RegCoefB:    cal_b = val;
      RegCoefQuad: cal_quad = val[31:0];
      RegCoefTemp: cal_temp = val[31:0];
      RegOsMode:   os_mode = val[1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued item has been sent and answered, then settle.
  task automatic drain();
    while (pending_samples.size() != 0 || sample.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  task automatic push_sample(input logic [15:0] ut, input logic [18:0] up);
    pending_samples.push_back('{ut: ut, up: up});
  endtask

  // Datasheet-like calibration with mild random spread.
  task automatic load_typical_cal(input logic [1:0] mode);
    write_reg(RegCoefA, {16'(408 + $urandom_range(64)), 16'(-72 + $urandom_range(16)),
                         16'(-14383 + $urandom_range(200))});
    write_reg(RegCoefB, {16'(32741 + $urandom_range(100)), 16'(32757 + $urandom_range(50)),
                         16'(23153 + $urandom_range(100))});
    write_reg(RegCoefQuad, {16'd0, 16'd6190, 16'd4});
    write_reg(RegCoefTemp, {16'd0, 16'(-8711 + $urandom_range(100)),
                            16'(2868 + $urandom_range(50))});
    write_reg(RegOsMode, {46'd0, mode});
  endtask

  task automatic load_random_cal();
    write_reg(RegCoefA, 48'({$urandom, $urandom}));
    write_reg(RegCoefB, 48'({$urandom, $urandom}));
    write_reg(RegCoefQuad, 48'({$urandom, $urandom}));
    write_reg(RegCoefTemp, 48'({$urandom, $urandom}));
    write_reg(RegOsMode, 48'({$urandom, $urandom}));
  endtask

  task automatic random_burst(input int n, input bit typical);
    repeat (n) begin
      if (typical)
        push_sample(16'(27898 + $urandom_range(4000) - 2000),
                    19'(($urandom_range(30000) + 10000) << os_mode));
      else
        push_sample(16'($urandom), 19'($urandom));
    end
  endtask

  initial begin
    sample.valid = 1'b0;
    sample.raw_temp_word = '0;
    sample.raw_press_word = '0;
    result.ready = 1'b0;
    cal_a = '0; cal_b = '0; cal_quad = '0; cal_temp = '0; os_mode = 2'd3;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration: ac5 = 0 and md = 0 zero the temperature divisor for any ut.
    push_sample(16'd0, 19'd0);
    push_sample(16'hFFFF, 19'h7FFFF);
    drain();

    // Directed: typical calibration, field extremes, each mode.
    for (int m = 0; m < 4; m++) begin
      load_typical_cal(2'(m));
      push_sample(16'd27898, 19'(23843 << m));
      push_sample(16'd0, 19'd0);
      push_sample(16'hFFFF, 19'h7FFFF);
      push_sample(16'hFFFF, 19'd0);
      push_sample(16'd0, 19'h7FFFF);
      drain();
    end
    // Temperature divisor zero: ut = ac6 and md = 0 with nonzero mc.
    write_reg(RegCoefTemp, {16'd0, 16'h8000, 16'd0});
    push_sample(cal_b[15:0], 19'd1000);
    drain();
    // Pressure divisor zero: ac4 = 0.
    write_reg(RegCoefB, {16'd0, 16'd32757, 16'd23153});
    write_reg(RegCoefTemp, {16'd0, 16'd8711, 16'd2868});
    push_sample(16'd27898, 19'd23843);
    // Saturated temperature: large mc over a tiny divisor.
    drain();
    write_reg(RegCoefB, {16'hFFFF, 16'hFFFF, 16'd0});
    write_reg(RegCoefTemp, {16'd0, 16'h7FFF, 16'd1});
    push_sample(16'd0, 19'd1);
    push_sample(16'hFFFF, 19'h7FFFF);
    drain();
    write_reg(RegCoefA, 48'hFFFF_FFFF_FFFF);
    write_reg(RegCoefQuad, 48'hFFFF_FFFF);
    write_reg(RegOsMode, 48'd0);
    push_sample(16'h8000, 19'h40000);
    drain();

    // Random: mostly realistic calibration with varying idling patterns.
    for (int ph = 0; ph < 10; ph++) begin
      send_idle_on = (ph != 3);
      recv_idle_on = (ph != 3);
      if (ph % 3 == 2) load_random_cal();
      else load_typical_cal(2'($urandom_range(3)));
      if (ph == 5) begin
        // Hold the sender until every outstanding result has come back.
        random_burst(40, 1'b1);
        while (pending_samples.size() > 20) @(posedge clk);
        send_hold = 1'b1;
        while (expected_results.size() != 0 || sample.valid) @(posedge clk);
        send_hold = 1'b0;
      end
      random_burst(110, ph % 3 != 2);
      random_burst(10, 1'b0);
      drain();
    end

    $display("covered %0d results (%0d divide faults) over 4 modes and random calibration",
             results_seen, faults_seen);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
